@@ rtl/thsdf_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, types and the arctangent table of the helix distance evaluator
package thsdf_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int RATE_FRAC = 24;
	localparam int ATAN_COUNT = 24;
	localparam int ROOT_BITS = 32;
	localparam int CW = 34;
	localparam int RW = ROOT_BITS + 3;
	localparam int TURN_W = 24;
	localparam int DIV_BITS = TURN_W + RATE_FRAC;

	localparam logic signed [31:0] HALF_PI_Q30 = 32'sd1686629713;
	localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	localparam logic [30:0] OUTER_RST = 31'd65536;
	localparam logic [30:0] INNER_RST = 31'd16384;
	localparam logic [30:0] OFFSET_RST = 31'd32768;
	localparam logic [30:0] HEIGHT_RST = 31'd262144;
	localparam logic [TURN_W-1:0] TURN_RST = 24'd65536;
	localparam logic [31:0] RATE_RST =
		32'((64'(TURN_RST) << RATE_FRAC) / 64'(HEIGHT_RST));

	typedef enum logic [2:0] {
		REG_OUTER,
		REG_INNER,
		REG_OFFSET,
		REG_HEIGHT,
		REG_TURNS
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic [1:0] quad;
	} pt_side_t;

	typedef struct packed {
		logic [63:0] v;
		logic [RW-1:0] rem;
		logic [ROOT_BITS-1:0] root;
	} isq_t;

	typedef struct packed {
		logic signed [31:0] pz;
		logic [2:0] sh;
	} dist_side_t;

	function automatic logic [CW-1:0] atan_q30(input int i);
		logic [CW-1:0] r;
		case (i)
			0: r = 34'd843314856;
			1: r = 34'd497837829;
			2: r = 34'd263043836;
			3: r = 34'd133525158;
			4: r = 34'd67021686;
			5: r = 34'd33543515;
			6: r = 34'd16775850;
			7: r = 34'd8388437;
			8: r = 34'd4194282;
			9: r = 34'd2097149;
			10: r = 34'd1048575;
			11: r = 34'd524287;
			12: r = 34'd262143;
			13: r = 34'd131071;
			14: r = 34'd65535;
			15: r = 34'd32767;
			16: r = 34'd16383;
			17: r = 34'd8191;
			18: r = 34'd4095;
			19: r = 34'd2047;
			20: r = 34'd1023;
			21: r = 34'd511;
			22: r = 34'd255;
			23: r = 34'd127;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/twisted_helix_sdf_eval.sv @@
`timescale 1ns / 1ps
// twisted helix signed distance evaluator, top level
//
// points come in on point_x/y/z with point_valid/point_stall, one transfer a
// cycle while point_stall is low; each point gives one signed_distance on dist_valid/dist_stall, in order.
// from the input transfer to dist_valid a point passes phase multiply, angle
// scaling, one cordic cell per stage, quadrant mapping, centre, range scaling,
// distance setup, 32 square root digit cells, term select and output register.
// throughput is one point per cycle while point_stall is low, the whole pipeline moves as one.
// when dist_valid is high and dist_stall is high the pipeline and the output
// hold and point_stall goes high in the same cycle.
// register writes go through cfg_valid/cfg_ready/cfg_index/cfg_data; the user must
// make them only while the pipeline is empty, the block itself does not enforce it.
// a write to a listed register recomputes the twist rate with a bit-serial divider;
// cfg_ready and point_stall stay busy until it ends. reset loads the default
// radii, height, turn count and their rate; no point or result is in flight after reset.
module twisted_helix_sdf_eval #(
	parameter int FRAC_BITS = thsdf_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STAGES = thsdf_pkg::CORDIC_STAGES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic point_valid,
	output logic point_stall,
	input logic signed [31:0] point_x,
	input logic signed [31:0] point_y,
	input logic signed [31:0] point_z,
	output logic dist_valid,
	input logic dist_stall,
	output logic signed [31:0] signed_distance,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data
);
	import thsdf_pkg::*;

	localparam int NS = CORDIC_STAGES;
	localparam int L = NS + 39;
	localparam int CNT_W = $clog2(DIV_BITS + 1);

	// configuration and twist rate
	logic [30:0] outer_q, inner_q, offset_q, height_q;
	logic [TURN_W-1:0] turn_q;
	logic [31:0] rate_q;
	logic busy_q, load_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_BITS-1:0] dvd_q;
	logic [30:0] rem_q;
	logic [31:0] remsh;
	logic qbit;

	assign cfg_ready = !busy_q;
	assign remsh = {rem_q, dvd_q[DIV_BITS-1]};
	assign qbit = remsh >= {1'b0, height_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_q <= OUTER_RST;
			inner_q <= INNER_RST;
			offset_q <= OFFSET_RST;
			height_q <= HEIGHT_RST;
			turn_q <= TURN_RST;
			rate_q <= RATE_RST;
			busy_q <= 1'b0;
			load_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			load_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_OUTER: outer_q <= cfg_data[30:0];
					REG_INNER: inner_q <= cfg_data[30:0];
					REG_OFFSET: offset_q <= cfg_data[30:0];
					REG_HEIGHT: height_q <= cfg_data[30:0];
					REG_TURNS: turn_q <= cfg_data[TURN_W-1:0];
					default: ;
				endcase
				if (cfg_index <= REG_TURNS) begin
					busy_q <= 1'b1;
					load_q <= 1'b1;
				end
			end else if (load_q) begin
				cnt_q <= CNT_W'(DIV_BITS);
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end else begin
					// zero height means no twist, big quotients saturate
					if (height_q == '0) begin
						rate_q <= '0;
					end else if (|dvd_q[DIV_BITS-1:32]) begin
						rate_q <= '1;
					end else begin
						rate_q <= dvd_q[31:0];
					end
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_q) begin
			dvd_q <= {turn_q, {RATE_FRAC{1'b0}}};
			rem_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= qbit ? 31'(remsh - {1'b0, height_q}) : remsh[30:0];
			dvd_q <= {dvd_q[DIV_BITS-2:0], qbit};
		end
	end

	// pipeline control
	logic en, acc;
	logic [L-1:0] vld_q;
	logic dist_valid_q;
	logic signed [31:0] dist_q;

	assign en = !dist_valid_q || !dist_stall;
	assign point_stall = !en || busy_q;
	assign acc = point_valid && !point_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			dist_valid_q <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], acc};
			dist_valid_q <= vld_q[L-1];
		end
	end

	// stage 1: phase as a wrapped fraction of one revolution
	logic signed [64:0] zprod;
	logic [31:0] phase_s1;
	logic signed [31:0] px_s1, py_s1, pz_s1;

	assign zprod = point_z * $signed({1'b0, rate_q});

	always_ff @(posedge clk) begin
		if (en) begin
			phase_s1 <= zprod[FRAC_BITS+23 -: 32];
			px_s1 <= point_x;
			py_s1 <= point_y;
			pz_s1 <= point_z;
		end
	end

	// stage 2: quadrant split and residual to radians
	logic [31:0] tph;
	logic signed [31:0] resid;
	logic signed [63:0] angp;
	logic signed [63:0] angp_s2;
	logic [1:0] quad_s2;
	logic signed [31:0] px_s2, py_s2, pz_s2;

	assign tph = phase_s1 + 32'h2000_0000;
	assign resid = $signed({2'b0, tph[29:0]}) - 32'sd536870912;
	assign angp = resid * HALF_PI_Q30;

	always_ff @(posedge clk) begin
		if (en) begin
			angp_s2 <= angp;
			quad_s2 <= tph[31:30];
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			pz_s2 <= pz_s1;
		end
	end

	// cordic row
	logic signed [CW-1:0] cx_w [NS+1];
	logic signed [CW-1:0] cy_w [NS+1];
	logic signed [CW-1:0] ca_w [NS+1];
	pt_side_t cs_w [NS+1];

	assign cx_w[0] = CORDIC_GAIN_Q30;
	assign cy_w[0] = '0;
	assign ca_w[0] = angp_s2[63:30];
	assign cs_w[0] = '{px: px_s2, py: py_s2, pz: pz_s2, quad: quad_s2};

	for (genvar i = 0; i < NS; i++) begin : g_cordic
		thsdf_cordic_cell #(.IDX(i)) u_cell (
			.clk(clk),
			.en(en),
			.x(cx_w[i]),
			.y(cy_w[i]),
			.ang(ca_w[i]),
			.side(cs_w[i]),
			.x_q(cx_w[i+1]),
			.y_q(cy_w[i+1]),
			.ang_q(ca_w[i+1]),
			.side_q(cs_w[i+1])
		);
	end

	// quadrant mapping
	logic signed [CW-1:0] c_n, s_n, c_sa, s_sa;
	pt_side_t side_sa;
	pt_side_t side_cd;

	assign side_cd = cs_w[NS];

	always_comb begin
		unique case (side_cd.quad)
			2'd0: begin c_n = cx_w[NS]; s_n = cy_w[NS]; end
			2'd1: begin c_n = -cy_w[NS]; s_n = cx_w[NS]; end
			2'd2: begin c_n = -cx_w[NS]; s_n = -cy_w[NS]; end
			default: begin c_n = cy_w[NS]; s_n = -cx_w[NS]; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_sa <= c_n;
			s_sa <= s_n;
			side_sa <= side_cd;
		end
	end

	// inner cylinder centre
	logic signed [65:0] cxp, cyp;
	logic signed [CW-1:0] cx_sb, cy_sb;
	logic signed [31:0] px_sb, py_sb, pz_sb;

	assign cxp = $signed({1'b0, offset_q}) * c_sa;
	assign cyp = $signed({1'b0, offset_q}) * s_sa;

	always_ff @(posedge clk) begin
		if (en) begin
			cx_sb <= cxp[63:30];
			cy_sb <= cyp[63:30];
			px_sb <= side_sa.px;
			py_sb <= side_sa.py;
			pz_sb <= side_sa.pz;
		end
	end

	// offsets to the three axes, magnitudes and range scaling
	logic signed [34:0] dx [3];
	logic signed [34:0] dy [3];
	logic [34:0] ax [3];
	logic [34:0] ay [3];
	logic [34:0] am [3];
	logic [31:0] a_n [3];
	logic [31:0] b_n [3];
	logic [2:0] sh_n;
	logic [31:0] a_sc [3];
	logic [31:0] b_sc [3];
	logic [2:0] sh_sc;
	logic signed [31:0] pz_sc;

	always_comb begin
		dx[0] = 35'(px_sb);
		dy[0] = 35'(py_sb);
		dx[1] = 35'(px_sb) - 35'(cx_sb);
		dy[1] = 35'(py_sb) - 35'(cy_sb);
		dx[2] = 35'(px_sb) + 35'(cx_sb);
		dy[2] = 35'(py_sb) + 35'(cy_sb);
		for (int k = 0; k < 3; k++) begin
			ax[k] = dx[k][34] ? 35'(-dx[k]) : 35'(dx[k]);
			ay[k] = dy[k][34] ? 35'(-dy[k]) : 35'(dy[k]);
			am[k] = (ax[k] > ay[k]) ? ax[k] : ay[k];
			sh_n[k] = |am[k][34:31];
			a_n[k] = sh_n[k] ? ax[k][33:2] : ax[k][31:0];
			b_n[k] = sh_n[k] ? ay[k][33:2] : ay[k][31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_sc <= a_n;
			b_sc <= b_n;
			sh_sc <= sh_n;
			pz_sc <= pz_sb;
		end
	end

	// squared lengths
	isq_t isq_w [3][ROOT_BITS+1];
	isq_t isq_sd [3];
	dist_side_t side_sd;
	logic [63:0] sq [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sq[k] = 64'(a_sc[k]) * 64'(a_sc[k]) + 64'(b_sc[k]) * 64'(b_sc[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				isq_sd[k] <= '{v: sq[k], rem: '0, root: '0};
			end
			side_sd <= '{pz: pz_sc, sh: sh_sc};
		end
	end

	// square root rows, one per distance
	for (genvar k = 0; k < 3; k++) begin : g_lane
		assign isq_w[k][0] = isq_sd[k];
		for (genvar j = 0; j < ROOT_BITS; j++) begin : g_digit
			thsdf_isqrt_cell #(.IDX(j)) u_cell (
				.clk(clk),
				.en(en),
				.cur(isq_w[k][j]),
				.nxt_q(isq_w[k][j+1])
			);
		end
	end

	dist_side_t side_dl_q [ROOT_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			side_dl_q[0] <= side_sd;
			for (int j = 1; j < ROOT_BITS; j++) begin
				side_dl_q[j] <= side_dl_q[j-1];
			end
		end
	end

	// the five terms
	dist_side_t side_rt;
	logic [33:0] rs [3];
	logic signed [35:0] term_n [5];
	logic signed [35:0] term_st [5];

	assign side_rt = side_dl_q[ROOT_BITS-1];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rs[k] = side_rt.sh[k] ? {isq_w[k][ROOT_BITS].root, 2'b00}
				: {2'b00, isq_w[k][ROOT_BITS].root};
		end
		term_n[0] = $signed({2'b0, rs[0]}) - $signed({5'b0, outer_q});
		term_n[1] = $signed({5'b0, inner_q}) - $signed({2'b0, rs[1]});
		term_n[2] = $signed({5'b0, inner_q}) - $signed({2'b0, rs[2]});
		term_n[3] = -36'(side_rt.pz);
		term_n[4] = 36'(side_rt.pz) - $signed({5'b0, height_q});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			term_st <= term_n;
		end
	end

	// maximum and saturation
	logic signed [35:0] m01, m23, m03, best;
	logic signed [31:0] dist_n;

	always_comb begin
		m01 = (term_st[1] > term_st[0]) ? term_st[1] : term_st[0];
		m23 = (term_st[3] > term_st[2]) ? term_st[3] : term_st[2];
		m03 = (m23 > m01) ? m23 : m01;
		best = (term_st[4] > m03) ? term_st[4] : m03;
		if (best > 36'sd2147483647) begin
			dist_n = 32'sh7FFF_FFFF;
		end else if (best < -36'sd2147483648) begin
			dist_n = 32'sh8000_0000;
		end else begin
			dist_n = best[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_q <= dist_n;
		end
	end

	assign dist_valid = dist_valid_q;
	assign signed_distance = dist_q;

endmodule

@@ rtl/thsdf_cordic_cell.sv @@
`timescale 1ns / 1ps
// one rotation-mode cordic cell with the point carried alongside
module thsdf_cordic_cell #(
	parameter int IDX = 0
) (
	input logic clk,
	input logic en,
	input logic signed [thsdf_pkg::CW-1:0] x,
	input logic signed [thsdf_pkg::CW-1:0] y,
	input logic signed [thsdf_pkg::CW-1:0] ang,
	input thsdf_pkg::pt_side_t side,
	output logic signed [thsdf_pkg::CW-1:0] x_q,
	output logic signed [thsdf_pkg::CW-1:0] y_q,
	output logic signed [thsdf_pkg::CW-1:0] ang_q,
	output thsdf_pkg::pt_side_t side_q
);
	import thsdf_pkg::*;

	logic signed [CW-1:0] xs, ys, at, x_n, y_n, a_n;

	assign xs = x >>> IDX;
	assign ys = y >>> IDX;
	assign at = atan_q30(IDX);

	always_comb begin
		if (!ang[CW-1]) begin
			x_n = x - ys;
			y_n = y + xs;
			a_n = ang - at;
		end else begin
			x_n = x + ys;
			y_n = y - xs;
			a_n = ang + at;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q <= x_n;
			y_q <= y_n;
			ang_q <= a_n;
			side_q <= side;
		end
	end

endmodule

@@ rtl/thsdf_isqrt_cell.sv @@
`timescale 1ns / 1ps
// one digit step of the pipelined integer square root
module thsdf_isqrt_cell #(
	parameter int IDX = 0
) (
	input logic clk,
	input logic en,
	input thsdf_pkg::isq_t cur,
	output thsdf_pkg::isq_t nxt_q
);
	import thsdf_pkg::*;

	localparam int K = ROOT_BITS - 1 - IDX;

	logic [RW-1:0] remsh, trial;
	isq_t nxt;

	assign remsh = {cur.rem[RW-3:0], cur.v[2*K+1 -: 2]};
	assign trial = {1'b0, cur.root, 2'b01};

	always_comb begin
		nxt.v = cur.v;
		if (remsh >= trial) begin
			nxt.rem = remsh - trial;
			nxt.root = {cur.root[ROOT_BITS-2:0], 1'b1};
		end else begin
			nxt.rem = remsh;
			nxt.root = {cur.root[ROOT_BITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nxt_q <= nxt;
		end
	end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking bench for the twisted helix distance evaluator: directed and random points
module tb_top;
	import thsdf_pkg::*;

	localparam int LAT = CORDIC_STAGES_DEF + 40;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic point_valid = 1'b0;
	logic point_stall;
	logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
	logic dist_valid;
	logic dist_stall = 1'b0;
	logic signed [31:0] signed_distance;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	twisted_helix_sdf_eval DUT (.*);

	// predictor copy of the register file
	logic [30:0] m_outer, m_inner, m_offset, m_height;
	logic [23:0] m_turns;
	logic [31:0] m_rate;

	point_t pending_points[$];
	logic signed [31:0] expected_dist[$];
	int n_mismatch = 0;
	int n_checked = 0;
	int n_sent = 0;
	int hold_cycles = 0;
	int send_gap = 0;
	int recv_gap = 0;
	bit burst_mode = 0;
	bit in_taken = 1'b0;

	initial forever #10 clk = ~clk;

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic signed [63:0] fshr(logic signed [63:0] v, int s);
		return v >>> s;
	endfunction

	function automatic logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic signed [63:0] hyp(logic signed [63:0] dx, logic signed [63:0] dy);
		logic [63:0] a, b, m;
		int s;
		a = dx < 0 ? -dx : dx;
		b = dy < 0 ? -dy : dy;
		m = a > b ? a : b;
		s = 0;
		if (m >= 64'd1 << 31) begin
			s = 2;
			a = a >> 2;
			b = b >> 2;
		end
		return isqrt(a * a + b * b) << s;
	endfunction

	function automatic void recompute_rate();
		logic [63:0] q;
		if (m_height == 0) begin
			m_rate = 0;
		end else begin
			q = (64'(m_turns) << RATE_FRAC) / 64'(m_height);
			m_rate = q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
		end
	endfunction

	function automatic logic signed [31:0] predict_distance(point_t p);
		logic [63:0] prod;
		logic [31:0] phase, t;
		logic [1:0] quad;
		logic signed [63:0] res, ang, x, y, xs, ys, c, s, cx, cy, best, term;
		logic signed [63:0] px, py, pz;
		logic signed [63:0] at[24];
		at = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
			16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
			65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
		px = p.x;
		py = p.y;
		pz = p.z;
		prod = 64'(pz) * 64'(m_rate);
		phase = prod[39:8];
		t = phase + 32'h2000_0000;
		quad = t[31:30];
		res = 64'(t[29:0]) - 64'h2000_0000;
		ang = fshr(res * 64'sd1686629713, 30);
		x = 64'sd652032874;
		y = 0;
		for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
			xs = fshr(x, i);
			ys = fshr(y, i);
			if (ang >= 0) begin
				x = x - ys; y = y + xs; ang = ang - at[i];
			end else begin
				x = x + ys; y = y - xs; ang = ang + at[i];
			end
		end
		case (quad)
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
		cx = fshr(64'(m_offset) * c, 30);
		cy = fshr(64'(m_offset) * s, 30);
		best = hyp(px, py) - 64'(m_outer);
		term = 64'(m_inner) - hyp(px - cx, py - cy);
		if (term > best) best = term;
		term = 64'(m_inner) - hyp(px + cx, py + cy);
		if (term > best) best = term;
		term = -pz;
		if (term > best) best = term;
		term = pz - 64'(m_height);
		if (term > best) best = term;
		if (best > 64'sh7FFF_FFFF) best = 64'sh7FFF_FFFF;
		if (best < -64'sh8000_0000) best = -64'sh8000_0000;
		return best[31:0];
	endfunction

	function automatic void queue_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		point_t p;
		p.x = x;
		p.y = y;
		p.z = z;
		pending_points = {pending_points, p};
	endfunction

	// input transfers are recorded at the rising edge
	always @(posedge clk) begin
		point_t p;
		in_taken <= arst_n && point_valid && !point_stall;
		if (arst_n && point_valid && !point_stall) begin
			p.x = point_x;
			p.y = point_y;
			p.z = point_z;
			expected_dist = {expected_dist, predict_distance(p)};
			n_sent++;
		end
	end

	// sender: inputs move on the falling edge, the payload holds while stalled
	always @(negedge clk) begin
		point_t p;
		if (arst_n && (!point_valid || in_taken)) begin
			if (send_gap > 0) begin
				point_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_points.size() > 0) begin
				p = pending_points.pop_front();
				point_x <= p.x;
				point_y <= p.y;
				point_z <= p.z;
				point_valid <= 1'b1;
				send_gap <= burst_mode ? 0 : ($urandom_range(0, 3) == 0 ?
					$urandom_range(0, 17) : 0);
			end else begin
				point_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus an optional long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				dist_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				dist_stall <= 1'b1;
			end else begin
				dist_stall <= 1'b0;
				if (dist_valid && !burst_mode)
					recv_gap <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 17) : 0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		logic signed [31:0] exp_d;
		if (arst_n && dist_valid && !dist_stall) begin
			if (expected_dist.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("unexpected distance %0d", signed_distance);
			end else begin
				exp_d = expected_dist.pop_front();
				n_checked++;
				if (exp_d !== signed_distance) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("distance mismatch: expected %0d actual %0d",
							exp_d, signed_distance);
				end
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] data);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_OUTER: m_outer = data[30:0];
			REG_INNER: m_inner = data[30:0];
			REG_OFFSET: m_offset = data[30:0];
			REG_HEIGHT: m_height = data[30:0];
			REG_TURNS: m_turns = data[23:0];
			default: ;
		endcase
		if (idx <= REG_TURNS) recompute_rate();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_bad_index(logic [2:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		while ((pending_points.size() > 0 || point_valid || expected_dist.size() > 0)
				&& guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (LAT + 10) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd_coord(logic [31:0] scale);
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0: v = $urandom();
			1: v = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0} ^ ($urandom() & 32'h0003_FFFF);
			default: v = ($urandom() % (scale * 3 + 1)) - scale;
		endcase
		return v;
	endfunction

	task automatic random_phase(int count);
		logic [31:0] sc;
		sc = 32'(m_outer) + 32'(m_offset) + 32'h10000;
		if (sc > 32'h3FFF_FFFF) sc = 32'h3FFF_FFFF;
		for (int i = 0; i < count; i++) begin
			logic [31:0] z;
			z = $urandom_range(0, 3) == 0 ? $urandom() :
				($urandom() % (32'(m_height) + 32'h2_0001)) - 32'h1_0000;
			queue_point(rnd_coord(sc), rnd_coord(sc), z);
		end
		drain();
	endtask

	initial begin
		m_outer = OUTER_RST;
		m_inner = INNER_RST;
		m_offset = OFFSET_RST;
		m_height = HEIGHT_RST;
		m_turns = TURN_RST;
		recompute_rate();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (LAT + 60) @(posedge clk);

		// directed: field extremes, caps, axis points
		queue_point(0, 0, 0);
		queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		queue_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0002_0000);
		queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
		queue_point(32'h0000_8000, 0, 32'h0001_0000);
		queue_point(32'hFFFF_8000, 0, 32'h0001_0000);
		queue_point(0, 32'h0000_C000, 32'h0002_0000);
		queue_point(0, 0, 32'h0004_0000);
		queue_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_4000);
		queue_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000);
		queue_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0003_0000);
		drain();

		random_phase(350);

		// long hold-off while the sender keeps pushing
		burst_mode = 1;
		for (int i = 0; i < 150; i++)
			queue_point($urandom() & 32'h0001_FFFF, $urandom() & 32'h0001_FFFF,
				$urandom() % 32'h4_0000);
		hold_cycles = 300;
		drain();
		burst_mode = 0;

		// zero height, rate overflow, invalid index
		write_reg(REG_HEIGHT, 0);
		write_bad_index(3'd5, 32'h1234);
		write_bad_index(3'd7, 32'hFFFF_FFFF);
		random_phase(200);
		write_reg(REG_HEIGHT, 1);
		write_reg(REG_TURNS, 24'hFF_FFFF);
		random_phase(200);

		// large extremes
		write_reg(REG_OUTER, 32'h7FFF_FFFF);
		write_reg(REG_INNER, 32'hFFFF_FFFF);
		write_reg(REG_OFFSET, 32'h7FFF_FFFF);
		write_reg(REG_HEIGHT, 32'h7FFF_FFFF);
		write_reg(REG_TURNS, 0);
		random_phase(200);

		// small extremes
		write_reg(REG_OUTER, 1);
		write_reg(REG_INNER, 0);
		write_reg(REG_OFFSET, 0);
		write_reg(REG_TURNS, 1);
		random_phase(150);

		// random mid-range settings
		for (int k = 0; k < 4; k++) begin
			write_reg(REG_OUTER, $urandom_range(1, 32'h0010_0000));
			write_reg(REG_INNER, $urandom_range(0, 32'h0004_0000));
			write_reg(REG_OFFSET, $urandom());
			write_reg(REG_HEIGHT, $urandom_range(1, 32'h0100_0000));
			write_reg(REG_TURNS, $urandom());
			random_phase(150);
		end

		if (expected_dist.size() > 0) n_mismatch++;
		$display("checked %0d distances over %0d points, several register settings",
			n_checked, n_sent);
		$display("mismatches: %0d", n_mismatch);
		if (n_mismatch == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/thsdf_pkg.sv
rtl/thsdf_cordic_cell.sv
rtl/thsdf_isqrt_cell.sv
rtl/twisted_helix_sdf_eval.sv
verif/tb_top.sv
